// ===== sv/spmf_pkg.sv =====
// Shared constants, result codes and control types for the strict-priority multi-level FIFO.
package spmf_pkg;

    localparam int LEVELS = 3;
    localparam int DEPTH  = 16;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 4;
    localparam int STAT_W  = 3;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int SUM_W   = PTR_W + 1;
    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam logic [STAT_W-1:0] STATUS_ENQUEUED  = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_DEQUEUED  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_PRIO  = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_EMPTY     = 3'd4;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mem_write;
        logic mem_read;
    } spmf_cmd_t;

    // Decisions the datapath takes from the request on offer.
    typedef struct packed {
        logic enq_write;
        logic deq_hit;
    } spmf_stat_t;

endpackage

// ===== sv/spmf_if.sv =====
// Request and response channel interfaces of the strict-priority multi-level FIFO.
interface spmf_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [spmf_pkg::VALUE_W-1:0] item_value;
    logic        [spmf_pkg::PRIO_W-1:0]  item_priority;

    modport source (output valid, output kind, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input kind, input item_value, input item_priority,
                    output ready);
endinterface

interface spmf_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [spmf_pkg::STAT_W-1:0]  status;
    logic signed [spmf_pkg::VALUE_W-1:0] out_value;
    logic        [spmf_pkg::PRIO_W-1:0]  out_priority;

    modport source (output valid, output status, output out_value, output out_priority,
                    input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                    output ready);
endinterface

// ===== sv/spmf_ctrl.sv =====
// Controller state machine: takes one request, holds its response until it is taken.
module spmf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  spmf_pkg::spmf_stat_t stat,
    output spmf_pkg::spmf_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = (state_reg == ST_HOLD);
    assign cmd.load      = req_valid && req_ready;
    assign cmd.mem_write = cmd.load && stat.enq_write;
    assign cmd.mem_read  = cmd.load && stat.deq_hit;

endmodule

// ===== sv/spmf_dp.sv =====
// Datapath: per-level counts and heads, the shared entry store and the response register.
module spmf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spmf_pkg::spmf_cmd_t                 cmd,
    output spmf_pkg::spmf_stat_t                stat,
    input  logic                                kind,
    input  logic signed [spmf_pkg::VALUE_W-1:0] item_value,
    input  logic        [spmf_pkg::PRIO_W-1:0]  item_priority,
    output logic        [spmf_pkg::STAT_W-1:0]  status,
    output logic signed [spmf_pkg::VALUE_W-1:0] out_value,
    output logic        [spmf_pkg::PRIO_W-1:0]  out_priority
);

    logic [spmf_pkg::CNT_W-1:0]   count_reg [spmf_pkg::LEVELS];
    logic [spmf_pkg::CNT_W-1:0]   count_next [spmf_pkg::LEVELS];
    logic [spmf_pkg::PTR_W-1:0]   head_reg [spmf_pkg::LEVELS];
    logic [spmf_pkg::PTR_W-1:0]   head_next [spmf_pkg::LEVELS];
    logic [spmf_pkg::VALUE_W-1:0] mem [spmf_pkg::ENTRIES];
    logic [spmf_pkg::VALUE_W-1:0] rd_data_reg;
    logic [spmf_pkg::STAT_W-1:0]  status_reg;
    logic [spmf_pkg::STAT_W-1:0]  status_next;
    logic [spmf_pkg::PRIO_W-1:0]  prio_reg;
    logic [spmf_pkg::PRIO_W-1:0]  prio_next;

    logic [spmf_pkg::PRIO_W-1:0]  enq_lv;
    logic                         prio_ok;
    logic [spmf_pkg::LEVELS-1:0]  enq_sel;
    logic [spmf_pkg::LEVELS-1:0]  deq_sel;
    logic                         any_found;
    logic                         enq_full;
    logic [spmf_pkg::ADDR_W-1:0]  enq_addr;
    logic [spmf_pkg::ADDR_W-1:0]  deq_addr;
    logic [spmf_pkg::PRIO_W-1:0]  deq_prio;
    logic [spmf_pkg::SUM_W-1:0]   tail_sum;
    logic [spmf_pkg::PTR_W-1:0]   tail_slot;
    logic [spmf_pkg::SUM_W-1:0]   head_sum;

    // Lane decode: one-hot selects for the enqueue level and for the most urgent
    // non-empty level, then OR-reduced addresses so no array is read at a signal index.
    always_comb
    begin
        enq_lv    = item_priority - spmf_pkg::PRIO_W'(1);
        prio_ok   = (item_priority != '0) &&
                    (item_priority <= spmf_pkg::PRIO_W'(spmf_pkg::LEVELS));
        any_found = 1'b0;
        enq_full  = 1'b0;
        enq_addr  = '0;
        deq_addr  = '0;
        deq_prio  = '0;
        tail_sum  = '0;
        tail_slot = '0;
        for (int l = 0; l < spmf_pkg::LEVELS; l++)
        begin
            enq_sel[l] = prio_ok && (enq_lv == spmf_pkg::PRIO_W'(l));
            deq_sel[l] = !any_found && (count_reg[l] != '0);
            any_found  = any_found || (count_reg[l] != '0);

            tail_sum   = spmf_pkg::SUM_W'(head_reg[l]) + spmf_pkg::SUM_W'(count_reg[l]);
            tail_slot  = (tail_sum >= spmf_pkg::SUM_W'(spmf_pkg::DEPTH)) ?
                         spmf_pkg::PTR_W'(tail_sum - spmf_pkg::SUM_W'(spmf_pkg::DEPTH)) :
                         spmf_pkg::PTR_W'(tail_sum);

            if (enq_sel[l])
            begin
                enq_full = (count_reg[l] == spmf_pkg::CNT_W'(spmf_pkg::DEPTH));
                enq_addr = spmf_pkg::ADDR_W'(l * spmf_pkg::DEPTH) +
                           spmf_pkg::ADDR_W'(tail_slot);
            end
            if (deq_sel[l])
            begin
                deq_addr = spmf_pkg::ADDR_W'(l * spmf_pkg::DEPTH) +
                           spmf_pkg::ADDR_W'(head_reg[l]);
                deq_prio = spmf_pkg::PRIO_W'(l + 1);
            end
        end
    end

    assign stat.enq_write = (kind == spmf_pkg::KIND_ENQUEUE) && prio_ok && !enq_full;
    assign stat.deq_hit   = (kind == spmf_pkg::KIND_DEQUEUE) && any_found;

    always_comb
    begin
        head_sum = '0;
        for (int l = 0; l < spmf_pkg::LEVELS; l++)
        begin
            count_next[l] = count_reg[l];
            head_next[l]  = head_reg[l];
            if (cmd.mem_write && enq_sel[l])
            begin
                count_next[l] = count_reg[l] + spmf_pkg::CNT_W'(1);
            end
            if (cmd.mem_read && deq_sel[l])
            begin
                head_sum      = spmf_pkg::SUM_W'(head_reg[l]) + spmf_pkg::SUM_W'(1);
                head_next[l]  = (head_sum >= spmf_pkg::SUM_W'(spmf_pkg::DEPTH)) ?
                                '0 : spmf_pkg::PTR_W'(head_sum);
                count_next[l] = count_reg[l] - spmf_pkg::CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        status_next = status_reg;
        prio_next   = prio_reg;
        if (cmd.load)
        begin
            if (kind == spmf_pkg::KIND_ENQUEUE)
            begin
                if (!prio_ok)
                begin
                    status_next = spmf_pkg::STATUS_BAD_PRIO;
                    prio_next   = '0;
                end
                else if (enq_full)
                begin
                    status_next = spmf_pkg::STATUS_FULL;
                    prio_next   = item_priority;
                end
                else
                begin
                    status_next = spmf_pkg::STATUS_ENQUEUED;
                    prio_next   = item_priority;
                end
            end
            else if (any_found)
            begin
                status_next = spmf_pkg::STATUS_DEQUEUED;
                prio_next   = deq_prio;
            end
            else
            begin
                status_next = spmf_pkg::STATUS_EMPTY;
                prio_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < spmf_pkg::LEVELS; l++)
            begin
                count_reg[l] <= '0;
                head_reg[l]  <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < spmf_pkg::LEVELS; l++)
            begin
                count_reg[l] <= count_next[l];
                head_reg[l]  <= head_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        prio_reg   <= prio_next;
    end

    // Entry store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[enq_addr] <= $unsigned(item_value);
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[deq_addr];
        end
    end

    assign status       = status_reg;
    assign out_priority = prio_reg;
    assign out_value    = (status_reg == spmf_pkg::STATUS_DEQUEUED) ?
                          $signed(rd_data_reg) : '0;

endmodule

// ===== sv/strict_priority_multi_fifo.sv =====
// Top level of the strict-priority multi-level FIFO.
// Usage:
//   req carries one request: kind 0 appends item_value to level item_priority
//   (1 is the most urgent), kind 1 removes the oldest value of the most urgent
//   non-empty level. rsp returns exactly one response per request with a status
//   (enqueued, dequeued, invalid priority, level full, all empty), the value
//   on a dequeue and the level concerned.
// Handshake:
//   A request is taken while the block is idle; its response is presented on
//   the cycle after acceptance. req.ready returns the cycle after the response
//   is taken, so no new request is taken until the last response is gone. This
//   is set by the registered read port of the shared entry store and the
//   response registers of the datapath, which hold until the response is taken.
// Reset:
//   rst_n clears every level count and head pointer, so all levels read empty;
//   stored entries are not cleared and need no clearing pass.
// Stalls:
//   While rsp.ready is low the response holds steady and no new request is taken.
module strict_priority_multi_fifo (
    input  logic       clk,
    input  logic       rst_n,
    spmf_req_if.sink   req,
    spmf_rsp_if.source rsp
);

    spmf_pkg::spmf_cmd_t  cmd;
    spmf_pkg::spmf_stat_t stat;

    spmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spmf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (req.kind),
        .item_value    (req.item_value),
        .item_priority (req.item_priority),
        .status        (rsp.status),
        .out_value     (rsp.out_value),
        .out_priority  (rsp.out_priority)
    );

`ifndef SYNTHESIS
    // A request is never taken while a response is still outstanding.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while a response is outstanding");

    // Every accepted request yields a response on the next cycle.
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid)
        else $error("no response after an accepted request");

    // Only a dequeue hit carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != spmf_pkg::STATUS_DEQUEUED)) |-> (rsp.out_value == '0))
        else $error("value present on a response that is not a dequeue");

    // An empty or invalid-priority response names no level.
    a_prio_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && ((rsp.status == spmf_pkg::STATUS_EMPTY) ||
                       (rsp.status == spmf_pkg::STATUS_BAD_PRIO)))
        |-> (rsp.out_priority == '0))
        else $error("level reported on an empty or invalid response");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the strict-priority multi-level FIFO: a directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import spmf_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } rsp_item_t;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic [5:0]                reps;
        logic                      typed;
        rsp_item_t                 rsp;
    } plan_row_t;

    localparam int PLAN_ROWS = 15;
    localparam int HOLD_CYCLES = 80;

    // Rows marked typed carry their response; the others take it from the predictor.
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{KIND_DEQUEUE, 32'sd0, 4'd0, 6'd1, 1'b1, '{STATUS_EMPTY, 32'sd0, 4'd0}},
        '{KIND_ENQUEUE, 32'sd5, 4'd0, 6'd1, 1'b1, '{STATUS_BAD_PRIO, 32'sd0, 4'd0}},
        '{KIND_ENQUEUE, 32'sd7, 4'd15, 6'd1, 1'b1, '{STATUS_BAD_PRIO, 32'sd0, 4'd0}},
        '{KIND_ENQUEUE, 32'sd9, 4'(LEVELS + 1), 6'd1, 1'b1, '{STATUS_BAD_PRIO, 32'sd0, 4'd0}},
        '{KIND_ENQUEUE, -32'sd1, 4'd3, 6'd1, 1'b1, '{STATUS_ENQUEUED, 32'sd0, 4'd3}},
        '{KIND_DEQUEUE, 32'h1234_5678, 4'd9, 6'd1, 1'b1, '{STATUS_DEQUEUED, -32'sd1, 4'd3}},
        '{KIND_ENQUEUE, 32'h7FFF_FFFF, 4'd2, 6'd1, 1'b1, '{STATUS_ENQUEUED, 32'sd0, 4'd2}},
        '{KIND_ENQUEUE, 32'h8000_0000, 4'd1, 6'd1, 1'b1, '{STATUS_ENQUEUED, 32'sd0, 4'd1}},
        '{KIND_ENQUEUE, 32'sd0, 4'd3, 6'd1, 1'b1, '{STATUS_ENQUEUED, 32'sd0, 4'd3}},
        '{KIND_DEQUEUE, 32'hFFFF_FFFF, 4'd15, 6'd1, 1'b1,
          '{STATUS_DEQUEUED, 32'h8000_0000, 4'd1}},
        '{KIND_DEQUEUE, 32'sd0, 4'd0, 6'd1, 1'b1, '{STATUS_DEQUEUED, 32'h7FFF_FFFF, 4'd2}},
        '{KIND_DEQUEUE, 32'sd0, 4'd0, 6'd1, 1'b1, '{STATUS_DEQUEUED, 32'sd0, 4'd3}},
        '{KIND_DEQUEUE, 32'sd0, 4'd0, 6'd1, 1'b1, '{STATUS_EMPTY, 32'sd0, 4'd0}},
        '{KIND_ENQUEUE, 32'h0000_0100, 4'd1, 6'(DEPTH), 1'b0, '{STATUS_ENQUEUED, 32'sd0, 4'd0}},
        '{KIND_ENQUEUE, 32'sd3, 4'd1, 6'd1, 1'b1, '{STATUS_FULL, 32'sd0, 4'd1}}
    };

    logic clk;
    logic rst_n;

    spmf_req_if req ();
    spmf_rsp_if rsp ();

    strict_priority_multi_fifo DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow of the queue contents.
    logic signed [VALUE_W-1:0] lvl_data [LEVELS][DEPTH];
    int                        lvl_fill [LEVELS];
    int                        lvl_head [LEVELS];

    rsp_item_t pending_rsp [$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_asks;
    int        hold_seen;
    int        hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic rsp_item_t predict_response(input logic kind,
                                                   input logic signed [VALUE_W-1:0] v,
                                                   input logic [PRIO_W-1:0] p);
        rsp_item_t r;
        int        lv;
        int        slot;
        logic      found;
        r = '{STATUS_EMPTY, 32'sd0, 4'd0};
        found = 1'b0;
        if (kind == KIND_ENQUEUE)
        begin
            if (p < 1 || p > LEVELS)
                r.status = STATUS_BAD_PRIO;
            else
            begin
                lv = p - 1;
                r.prio = p;
                if (lvl_fill[lv] >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    slot = (lvl_head[lv] + lvl_fill[lv]) % DEPTH;
                    lvl_data[lv][slot] = v;
                    lvl_fill[lv] = lvl_fill[lv] + 1;
                    r.status = STATUS_ENQUEUED;
                end
            end
        end
        else
        begin
            for (lv = 0; lv < LEVELS; lv++)
            begin
                if (!found && lvl_fill[lv] > 0)
                begin
                    found = 1'b1;
                    r.status = STATUS_DEQUEUED;
                    r.value = lvl_data[lv][lvl_head[lv]];
                    r.prio = PRIO_W'(lv + 1);
                    lvl_head[lv] = (lvl_head[lv] + 1) % DEPTH;
                    lvl_fill[lv] = lvl_fill[lv] - 1;
                end
            end
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic push_request(input logic kind, input logic signed [VALUE_W-1:0] v,
                                input logic [PRIO_W-1:0] p, input logic typed,
                                input rsp_item_t typed_rsp);
        rsp_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid         <= 1'b0;
            req.kind          <= 1'($urandom);
            req.item_value    <= $urandom;
            req.item_priority <= 4'($urandom);
            @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.kind          <= kind;
        req.item_value    <= v;
        req.item_priority <= p;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = predict_response(kind, v, p);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge clk);
    endtask

    // Response checker.
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing outstanding: status %0d", rsp.status);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.out_value !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d", want.value, rsp.out_value);
                    errors++;
                end
                if (rsp.out_priority !== want.prio)
                begin
                    $error("out_priority: expected %0d, got %0d", want.prio, rsp.out_priority);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure: random stalls and an occasional long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int                        row;
        int                        n;
        int                        phase;
        int                        burst_left;
        int                        enq_pct;
        int                        fav_level;
        logic                      kind;
        logic signed [VALUE_W-1:0] v;
        logic [PRIO_W-1:0]         p;

        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_asks = 0;
        hold_seen = 0;
        hold_left = 0;
        burst_left = 0;
        enq_pct = 50;
        fav_level = 1;
        for (n = 0; n < LEVELS; n++)
        begin
            lvl_fill[n] = 0;
            lvl_head[n] = 0;
        end
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.kind          <= KIND_ENQUEUE;
        req.item_value    <= '0;
        req.item_priority <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PLAN_ROWS; row++)
        begin
            for (n = 0; n < PLAN[row].reps; n++)
                push_request(PLAN[row].kind, PLAN[row].value + n, PLAN[row].prio,
                             PLAN[row].typed, PLAN[row].rsp);
        end
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (n = 0; n < 250; n++)
            begin
                if (phase == 0 && n == 100)
                    hold_asks = hold_asks + 1;
                // Bursts lean towards filling or draining, or stay balanced, mostly around one level.
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 10);
                    case ($urandom_range(2))
                        0: enq_pct = 80;
                        1: enq_pct = 20;
                        default: enq_pct = 50;
                    endcase
                    fav_level = $urandom_range(LEVELS, 1);
                end
                burst_left = burst_left - 1;
                kind = ($urandom_range(99) < enq_pct) ? KIND_ENQUEUE : KIND_DEQUEUE;
                case ($urandom_range(11))
                    0: v = -32'sd1;
                    1: v = 32'sd0;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = $urandom;
                endcase
                case ($urandom_range(9))
                    0: p = 4'($urandom);
                    1, 2: p = 4'($urandom_range(LEVELS, 1));
                    default: p = 4'(fav_level);
                endcase
                push_request(kind, v, p, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
